### hdl/acsm_pkg.sv
// ============================================================================
// acsm_pkg - shared definitions for the Aho-Corasick stream matcher
// Sizes, command codes, beat layouts and the link memory word formats.
// ============================================================================
package acsm_pkg;

  // Automaton sizes.
  localparam int NODES          = 1024;
  localparam int ALPHABET       = 256;
  localparam int OUTPUT_ENTRIES = 1024;
  localparam int MAX_MATCHES    = 64;

  // Field widths of the beats.
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 10;
  localparam int BYTE_W  = 8;
  localparam int LINK_W  = 11;
  localparam int PAT_W   = 16;
  localparam int POS_W   = 48;

  // Derived storage widths.
  localparam int NODE_W   = $clog2(NODES);
  localparam int SYM_W    = $clog2(ALPHABET);
  localparam int ENTRY_W  = $clog2(OUTPUT_ENTRIES);
  localparam int TBL_AW   = NODE_W + SYM_W;
  localparam int REGION_W = (NODE_W > ENTRY_W) ? NODE_W : ENTRY_W;
  localparam int LINK_AW  = REGION_W + 1;
  localparam int LINK_DW  = LINK_W + PAT_W;
  localparam int PAD_W    = LINK_DW - 2 * LINK_W;
  localparam int HOP_W    = $clog2(NODES + 2);
  localparam int CNT_W    = $clog2(MAX_MATCHES + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_TRANS = 3'd0,
    CMD_WR_NODE  = 3'd1,
    CMD_WR_ENTRY = 3'd2,
    CMD_RESTART  = 3'd3,
    CMD_SCAN     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_NODE,
    WS_ENTRY,
    WS_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] symbol;
    logic [IDX_W-1:0]  next_state;
    logic [LINK_W-1:0] link_a;
    logic [LINK_W-1:0] link_b;
    logic [PAT_W-1:0]  pattern;
    logic [POS_W-1:0]  position;
    logic              emit;
  } in_beat_t;

  typedef struct packed {
    logic [PAT_W-1:0] match_pat;
    logic [POS_W-1:0] end_position;
    logic             last;
    logic             overflow;
  } out_beat_t;

  // Hand-off from the transition stepper to the match walker.
  typedef struct packed {
    logic              start;
    logic [NODE_W-1:0] node;
    logic [POS_W-1:0]  position;
  } scan_req_t;

  // Link memory words: node links in the lower region, output entries above.
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] suffix;
  } node_word_t;

  typedef struct packed {
    logic [LINK_W-1:0] next;
    logic [PAT_W-1:0]  pattern;
  } entry_word_t;

endpackage

### hdl/acsm_step.sv
// ============================================================================
// acsm_step - transition table and current node
// Holds the full DFA table and steps the current node one byte per scan.
// ============================================================================
module acsm_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  acsm_pkg::in_beat_t  beat,
  output acsm_pkg::scan_req_t scan
);
  import acsm_pkg::*;

  logic [NODE_W-1:0] tbl_mem [0:2**TBL_AW-1];
  logic [NODE_W-1:0] rd_data;
  logic              tbl_we;
  logic              tbl_re;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [TBL_AW-1:0] tbl_raddr;

  logic [NODE_W-1:0] cur_r, cur_nxt, cur_eff;
  logic              pend_r, pend_nxt;
  logic              pend_emit_r, pend_emit_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  // A scan issued last cycle has its target in the read register now.
  assign cur_eff   = pend_r ? rd_data : cur_r;
  assign tbl_waddr = {beat.index[NODE_W-1:0], beat.symbol[SYM_W-1:0]};
  assign tbl_raddr = {cur_eff, beat.symbol[SYM_W-1:0]};

  always_comb begin
    cur_nxt       = cur_eff;
    pend_nxt      = 1'b0;
    pend_emit_nxt = pend_emit_r;
    pos_nxt       = pos_r;
    tbl_we        = 1'b0;
    tbl_re        = 1'b0;
    if (acc) begin
      case (cmd_t'(beat.cmd))
        CMD_WR_TRANS: begin
          tbl_we = 1'b1;
        end
        CMD_RESTART: begin
          cur_nxt = '0;
        end
        CMD_SCAN: begin
          tbl_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_emit_nxt = beat.emit;
          pos_nxt       = beat.position;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= beat.next_state[NODE_W-1:0];
    end
    if (tbl_re) begin
      rd_data <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cur_r  <= cur_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_emit_r <= pend_emit_nxt;
    pos_r       <= pos_nxt;
  end

  assign scan.start    = pend_r && pend_emit_r;
  assign scan.node     = rd_data;
  assign scan.position = pos_r;

endmodule

### hdl/acsm_walk.sv
// ============================================================================
// acsm_walk - match list walker
// Holds node links and output entries in one memory and walks the suffix chain and
// output lists into an output register, one memory read per cycle while no result stalls it.
// ============================================================================
module acsm_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  acsm_pkg::in_beat_t  beat,
  input  acsm_pkg::scan_req_t scan,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output acsm_pkg::out_beat_t out_data
);
  import acsm_pkg::*;

  logic [LINK_DW-1:0] link_mem [0:2**LINK_AW-1];
  logic [LINK_DW-1:0] rd_data;
  logic               mem_we;
  logic [LINK_AW-1:0] mem_waddr;
  logic [LINK_DW-1:0] mem_wdata;
  logic               mem_re;
  logic [LINK_AW-1:0] mem_raddr;

  walk_state_t state_r, state_nxt;

  logic [HOP_W-1:0]  hops_r, hops_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LINK_W-1:0] suf_r, suf_nxt;
  logic              first_r, first_nxt;
  logic              extra_r, extra_nxt;
  logic              drop_r, drop_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [PAT_W-1:0]  pend_pat_r, pend_pat_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;

  node_word_t        nw;
  entry_word_t       ew;
  logic              head_ok;
  logic              entry_ok;
  logic              extra_eff;
  logic [HOP_W-1:0]  hop_lim;
  logic [LINK_W-1:0] chain_link;
  logic              node_ok;
  logic [CNT_W-1:0]  cnt_inc;
  logic              cnt_full;
  logic              full_after;
  logic              out_free;
  logic              hold;
  logic              push;
  out_beat_t         push_beat;

  // ---- link memory writes from the command stream ----
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (acc) begin
      case (cmd_t'(beat.cmd))
        CMD_WR_NODE: begin
          mem_we    = 1'b1;
          mem_waddr = {1'b0, REGION_W'(beat.index[NODE_W-1:0])};
          mem_wdata = node_word_t'{pad: '0, head: beat.link_a, suffix: beat.link_b};
        end
        CMD_WR_ENTRY: begin
          mem_we    = 1'b1;
          mem_waddr = {1'b1, REGION_W'(beat.index[ENTRY_W-1:0])};
          mem_wdata = entry_word_t'{next: beat.link_a, pattern: beat.pattern};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= link_mem[mem_raddr];
    end
  end

  // ---- walk decisions ----
  assign nw         = node_word_t'(rd_data);
  assign ew         = entry_word_t'(rd_data);
  assign head_ok    = nw.head < LINK_W'(OUTPUT_ENTRIES);
  assign entry_ok   = ew.next < LINK_W'(OUTPUT_ENTRIES);
  // Without an own output the chain may run one node further.
  assign extra_eff  = first_r ? !head_ok : extra_r;
  assign hop_lim    = extra_eff ? HOP_W'(NODES + 1) : HOP_W'(NODES);
  assign chain_link = (state_r == WS_NODE) ? nw.suffix : suf_r;
  assign node_ok    = (chain_link < LINK_W'(NODES)) && (hops_r < hop_lim);
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign cnt_full   = cnt_r == CNT_W'(MAX_MATCHES);
  assign full_after = cnt_inc == CNT_W'(MAX_MATCHES);
  assign out_free   = !out_valid_r || !out_stall;
  assign hold       = pend_valid_r && !out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      WS_IDLE: begin
        if (scan.start) begin
          state_nxt = WS_NODE;
        end
      end
      WS_NODE: begin
        if (head_ok) begin
          state_nxt = cnt_full ? WS_FLUSH : WS_ENTRY;
        end else begin
          state_nxt = node_ok ? WS_NODE : WS_FLUSH;
        end
      end
      WS_ENTRY: begin
        if (!hold) begin
          if (entry_ok) begin
            state_nxt = full_after ? WS_FLUSH : WS_ENTRY;
          end else begin
            state_nxt = node_ok ? WS_NODE : WS_FLUSH;
          end
        end
      end
      WS_FLUSH: begin
        if (!hold) begin
          state_nxt = WS_IDLE;
        end
      end
      default: begin
        state_nxt = WS_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_re         = 1'b0;
    mem_raddr      = '0;
    hops_nxt       = hops_r;
    cnt_nxt        = cnt_r;
    suf_nxt        = suf_r;
    first_nxt      = first_r;
    extra_nxt      = extra_r;
    drop_nxt       = drop_r;
    pend_valid_nxt = pend_valid_r;
    pend_pat_nxt   = pend_pat_r;
    pos_nxt        = pos_r;
    push           = 1'b0;
    push_beat      = out_beat_t'{match_pat: pend_pat_r, end_position: pos_r,
                                 last: 1'b0, overflow: 1'b0};
    case (state_r)
      WS_IDLE: begin
        if (scan.start) begin
          mem_re         = 1'b1;
          mem_raddr      = {1'b0, REGION_W'(scan.node)};
          hops_nxt       = HOP_W'(1);
          cnt_nxt        = '0;
          first_nxt      = 1'b1;
          drop_nxt       = 1'b0;
          pend_valid_nxt = 1'b0;
          pos_nxt        = scan.position;
        end
      end
      WS_NODE: begin
        first_nxt = 1'b0;
        extra_nxt = extra_eff;
        suf_nxt   = nw.suffix;
        if (head_ok) begin
          if (cnt_full) begin
            drop_nxt = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = {1'b1, REGION_W'(nw.head[ENTRY_W-1:0])};
          end
        end else if (node_ok) begin
          mem_re    = 1'b1;
          mem_raddr = {1'b0, REGION_W'(nw.suffix[NODE_W-1:0])};
          hops_nxt  = hops_r + HOP_W'(1);
        end
      end
      WS_ENTRY: begin
        if (!hold) begin
          // The previous match is known not to be the last one.
          push           = pend_valid_r;
          pend_pat_nxt   = ew.pattern;
          pend_valid_nxt = 1'b1;
          cnt_nxt        = cnt_inc;
          if (entry_ok) begin
            if (full_after) begin
              drop_nxt = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = {1'b1, REGION_W'(ew.next[ENTRY_W-1:0])};
            end
          end else if (node_ok) begin
            mem_re    = 1'b1;
            mem_raddr = {1'b0, REGION_W'(suf_r[NODE_W-1:0])};
            hops_nxt  = hops_r + HOP_W'(1);
          end
        end
      end
      WS_FLUSH: begin
        if (!hold) begin
          push               = pend_valid_r;
          push_beat.last     = 1'b1;
          push_beat.overflow = drop_r;
          pend_valid_nxt     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // ---- output register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_beat;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= WS_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hops_r     <= hops_nxt;
    cnt_r      <= cnt_nxt;
    suf_r      <= suf_nxt;
    first_r    <= first_nxt;
    extra_r    <= extra_nxt;
    drop_r     <= drop_nxt;
    pend_pat_r <= pend_pat_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = state_r != WS_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/aho_corasick_stream_matcher_core.sv
// ============================================================================
// aho_corasick_stream_matcher_core - multi-pattern byte stream matcher
// Full-DFA Aho-Corasick matcher: table and link loads, restart and byte scans
// with reporting of every pattern that ends at the scanned byte.
// ============================================================================
//
//   Channel  Ports                          Direction  Beat
//   -------  -----------------------------  ---------  ----------------------
//   in       in_valid, in_stall, in_data    sink       command / scan byte
//   out      out_valid, out_stall, out_data source     one match result
//
// Loads, restarts and scans without reporting follow back to back, since the
// next table address is taken straight from the transition table read
// register. A reporting scan reads the node's links, then the links of each
// node visited on the dictionary-suffix chain and each match entry, one at a
// time through the single read port of the link memory, and then hands off
// the final result.
// Reset puts the automaton at the root and clears its pending scan, walk
// state and output valid flag; the stores are not cleared and must be
// loaded before use. A stalled result halts the walk at its next match or at
// the final hand-off; the input is stalled while a walk is running.
//
module aho_corasick_stream_matcher_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acsm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acsm_pkg::out_beat_t out_data
);
  import acsm_pkg::*;

  logic      acc;
  logic      walk_busy;
  scan_req_t scan;

  // A reporting scan whose table read is landing hands over to the walker
  // this cycle, so no new beat is taken until that walk has finished.
  assign in_stall = walk_busy || scan.start;
  assign acc      = in_valid && !in_stall;

  acsm_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .beat  (in_data),
    .scan  (scan)
  );

  acsm_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .beat      (in_data),
    .scan      (scan),
    .busy      (walk_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The walker must be idle whenever a new walk is handed over.
  assert property (@(posedge clk) disable iff (!rst_n) scan.start |-> !walk_busy)
    else $error("walk start while the walker is busy");

  // Overflow is only ever flagged on the closing result of a byte.
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_data.overflow) |-> out_data.last)
    else $error("overflow flagged on a result that is not the last");

  // Results only come out of a running walk.
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(walk_busy))
    else $error("result appeared without a walk");

endmodule

### tb/aho_corasick_stream_matcher_core_test.sv
// ============================================================================
// aho_corasick_stream_matcher_core_test - self-checking bench for the matcher
// Loads small automata into the matcher, scans bytes through them and checks
// every match beat against a shadow automaton kept inside the bench. A short
// hand-written table comes first, then randomized load/scan phases with
// random idle bursts on both channels.
// ============================================================================
`timescale 1ns / 1ps

module aho_corasick_stream_matcher_core_test;
  import acsm_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int RAND_ITEMS   = 240;
  // The last stretch of random beats runs with no idling on either side.
  localparam int CALM_TAIL    = 60;
  // Longest walk: a full pass around a looping suffix chain plus the result limit.
  localparam int DRAIN_CYCLES = NODES + MAX_MATCHES + 16;
  // Worst case is roughly 300 beats of a full chain walk with 64 stalled
  // results each; this is several times that.
  localparam int LIMIT_NS     = 20_000_000;

  // Commands the block has no use for.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Link values at or above the store size mean "no link".
  localparam logic [LINK_W-1:0] LINK_NONE     = 11'd1024;
  localparam logic [LINK_W-1:0] LINK_NONE_TOP = 11'h7FF;

  // One row of the hand-written table. A typed row carries its own
  // expectation (none, or a single match); the others go to the predictor.
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    bit        has_hit;
    out_beat_t hit;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  aho_corasick_stream_matcher_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow automaton. These mirror the block's stores and are only ever read
  // at entries that the stimulus has written.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]  shadow_next [NODES*ALPHABET];
  logic [LINK_W-1:0] shadow_head [NODES];
  logic [LINK_W-1:0] dict_link   [NODES];
  logic [LINK_W-1:0] entry_link  [OUTPUT_ENTRIES];
  logic [PAT_W-1:0]  entry_pid   [OUTPUT_ENTRIES];
  logic [IDX_W-1:0]  dfa_node = '0;

  // Match beats still owed by the block, oldest first.
  out_beat_t pending_matches [$];

  // Nodes, byte values and output entries that the current random phase has
  // loaded. Only these are ever reached by a scan within the phase.
  int unsigned act_nodes [$];
  int unsigned act_syms  [$];
  int unsigned act_ents  [$];

  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned live_beats = 0;
  int unsigned scan_beats = 0;
  int unsigned rand_start = 0;
  int unsigned results_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned stall_left = 0;
  logic [POS_W-1:0] stream_pos = '0;

  // Step the shadow automaton by one accepted input beat and, for a reporting
  // scan, queue the matches that end at this byte. With keep cleared only the
  // state moves; the caller supplies the expectation itself.
  task automatic predict_matches(input in_beat_t b, input bit keep);
    int unsigned node;
    int unsigned ent;
    int unsigned hops;
    int unsigned found;
    bit          own;
    bit          suf;
    bit          dropped;
    bit          held;
    out_beat_t   hit;
    node    = 0;
    ent     = 0;
    hops    = 0;
    found   = 0;
    dropped = 1'b0;
    held    = 1'b0;
    hit     = '0;
    case (b.cmd)
      CMD_WR_TRANS: shadow_next[{b.index, b.symbol}] = b.next_state;
      CMD_WR_NODE: begin
        shadow_head[b.index] = b.link_a;
        dict_link[b.index]   = b.link_b;
      end
      CMD_WR_ENTRY: begin
        entry_link[b.index] = b.link_a;
        entry_pid[b.index]  = b.pattern;
      end
      CMD_RESTART: dfa_node = '0;
      CMD_SCAN: begin
        // A 10-bit target always names a real node, so no root fallback here.
        dfa_node = shadow_next[{dfa_node, b.symbol}];
        if (b.emit) begin
          own = shadow_head[dfa_node] < OUTPUT_ENTRIES;
          suf = dict_link[dfa_node] < NODES;
          if (own || suf) begin
            node = own ? int'(dfa_node) : int'(dict_link[dfa_node]);
            // The hop cap keeps a looping suffix chain from walking forever.
            while (node < NODES && hops < NODES && !dropped) begin
              ent = shadow_head[node];
              while (ent < OUTPUT_ENTRIES && !dropped) begin
                if (found == MAX_MATCHES) begin
                  dropped = 1'b1;
                end else begin
                  // Hold one match back so the final one can be marked.
                  if (held && keep) pending_matches.push_back(hit);
                  hit.match_pat    = entry_pid[ent];
                  hit.end_position = b.position;
                  hit.last         = 1'b0;
                  hit.overflow     = 1'b0;
                  held  = 1'b1;
                  found++;
                  ent = entry_link[ent];
                end
              end
              node = dict_link[node];
              hops++;
            end
          end
          if (held && keep) begin
            hit.last     = 1'b1;
            hit.overflow = dropped;
            pending_matches.push_back(hit);
          end
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side. A beat is offered, optionally after an idle burst, and held
  // until the block takes it; the shadow automaton steps on acceptance.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_beat_t b, input bit keep);
    if (live_beats - rand_start >= RAND_ITEMS - CALM_TAIL) calm = 1'b1;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_matches(b, keep);
    if (b.cmd <= CMD_SCAN) live_beats++;
    if (b.cmd == CMD_SCAN) scan_beats++;
  endtask

  function automatic in_beat_t mk_beat(input logic [CMD_W-1:0] c, input int unsigned idx,
                                       input int unsigned sym, input int unsigned nxt,
                                       input int unsigned la, input int unsigned lb,
                                       input int unsigned pat, input logic [POS_W-1:0] pos,
                                       input bit emit);
    in_beat_t b;
    b.cmd        = c;
    b.index      = IDX_W'(idx);
    b.symbol     = BYTE_W'(sym);
    b.next_state = IDX_W'(nxt);
    b.link_a     = LINK_W'(la);
    b.link_b     = LINK_W'(lb);
    b.pattern    = PAT_W'(pat);
    b.position   = pos;
    b.emit       = emit;
    return b;
  endfunction

  // Every field random; callers then pin the fields that matter for safety.
  function automatic in_beat_t rand_beat(input logic [CMD_W-1:0] c);
    in_beat_t b;
    b.cmd        = c;
    b.index      = IDX_W'($urandom);
    b.symbol     = BYTE_W'($urandom);
    b.next_state = IDX_W'($urandom);
    b.link_a     = LINK_W'($urandom);
    b.link_b     = LINK_W'($urandom);
    b.pattern    = PAT_W'($urandom);
    b.position   = {16'($urandom), 32'($urandom)};
    b.emit       = 1'($urandom);
    return b;
  endfunction

  function automatic dir_row_t quiet_row(input in_beat_t b);
    dir_row_t r;
    r.beat    = b;
    r.typed   = 1'b1;
    r.has_hit = 1'b0;
    r.hit     = '0;
    return r;
  endfunction

  function automatic dir_row_t single_row(input in_beat_t b, input out_beat_t hit);
    dir_row_t r;
    r.beat    = b;
    r.typed   = 1'b1;
    r.has_hit = 1'b1;
    r.hit     = hit;
    return r;
  endfunction

  function automatic dir_row_t checked_row(input in_beat_t b);
    dir_row_t r;
    r.beat    = b;
    r.typed   = 1'b0;
    r.has_hit = 1'b0;
    r.hit     = '0;
    return r;
  endfunction

  function automatic bit in_list(input int unsigned q[$], input int unsigned v);
    foreach (q[i]) begin
      if (q[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [LINK_W-1:0] none_link(input int unsigned floor_val);
    return LINK_W'($urandom_range(floor_val, 2**LINK_W - 1));
  endfunction

  function automatic logic [IDX_W-1:0] pick_node();
    return IDX_W'(act_nodes[$urandom_range(0, act_nodes.size() - 1)]);
  endfunction

  // Output list link: mostly to an entry loaded earlier in the phase, which
  // keeps lists acyclic, now and then to any loaded entry, which may loop.
  function automatic logic [LINK_W-1:0] pick_entry_link(input int unsigned below);
    if ($urandom_range(0, 3) == 0) return none_link(OUTPUT_ENTRIES);
    if (below == 0 || $urandom_range(0, 7) == 0)
      return LINK_W'(act_ents[$urandom_range(0, act_ents.size() - 1)]);
    return LINK_W'(act_ents[$urandom_range(0, below - 1)]);
  endfunction

  // Suffix link, built the same way over the phase's nodes.
  function automatic logic [LINK_W-1:0] pick_suffix(input int unsigned below);
    if ($urandom_range(0, 2) == 0) return none_link(NODES);
    if (below == 0 || $urandom_range(0, 7) == 0) return LINK_W'(pick_node());
    return LINK_W'(act_nodes[$urandom_range(0, below - 1)]);
  endfunction

  // One random phase: load a small automaton over a handful of byte values,
  // return to the root, then scan with the odd restart, mutation and noise.
  task automatic run_phase();
    int unsigned n_scans;
    in_beat_t    b;
    act_nodes.delete();
    act_syms.delete();
    act_ents.delete();
    act_nodes.push_back(0);
    repeat ($urandom_range(3, 7)) act_nodes.push_back($urandom_range(1, NODES - 1));
    repeat ($urandom_range(3, 6)) act_syms.push_back($urandom_range(0, ALPHABET - 1));
    repeat ($urandom_range(2, 8)) act_ents.push_back($urandom_range(0, OUTPUT_ENTRIES - 1));
    calm = (live_beats - rand_start >= RAND_ITEMS - CALM_TAIL) || ($urandom_range(0, 3) == 0);
    stream_pos = {16'($urandom), 32'($urandom)};

    foreach (act_ents[i]) begin
      b = rand_beat(CMD_WR_ENTRY);
      b.index  = IDX_W'(act_ents[i]);
      b.link_a = pick_entry_link(i);
      send_item(b, 1'b1);
    end
    foreach (act_nodes[i]) begin
      b = rand_beat(CMD_WR_NODE);
      b.index  = IDX_W'(act_nodes[i]);
      b.link_a = pick_entry_link(act_ents.size());
      b.link_b = pick_suffix(i);
      send_item(b, 1'b1);
    end
    foreach (act_nodes[i]) begin
      foreach (act_syms[k]) begin
        b = rand_beat(CMD_WR_TRANS);
        b.index      = IDX_W'(act_nodes[i]);
        b.symbol     = BYTE_W'(act_syms[k]);
        b.next_state = pick_node();
        send_item(b, 1'b1);
      end
    end
    send_item(rand_beat(CMD_RESTART), 1'b1);

    n_scans = $urandom_range(25, 45);
    repeat (n_scans) begin
      // Stop scanning once the run has sent its share of beats.
      if (live_beats - rand_start >= RAND_ITEMS) break;
      case ($urandom_range(0, 19))
        0: b = rand_beat(CMD_RESTART);
        1: b = rand_beat(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
        2: begin
          // Load outside the live automaton: never reached in this phase.
          case ($urandom_range(0, 2))
            0:       b = rand_beat(CMD_WR_TRANS);
            1:       b = rand_beat(CMD_WR_NODE);
            default: b = rand_beat(CMD_WR_ENTRY);
          endcase
          while (b.cmd == CMD_WR_ENTRY ? in_list(act_ents, b.index)
                                       : in_list(act_nodes, b.index))
            b.index = IDX_W'($urandom);
        end
        3: begin
          // Rewire the live automaton mid-stream, staying inside it.
          if ($urandom_range(0, 1) == 0) begin
            b = rand_beat(CMD_WR_TRANS);
            b.index      = pick_node();
            b.symbol     = BYTE_W'(act_syms[$urandom_range(0, act_syms.size() - 1)]);
            b.next_state = pick_node();
          end else begin
            b = rand_beat(CMD_WR_NODE);
            b.index  = pick_node();
            b.link_a = pick_entry_link(act_ents.size());
            b.link_b = pick_suffix($urandom_range(0, act_nodes.size()));
          end
        end
        default: begin
          b = rand_beat(CMD_SCAN);
          b.symbol = BYTE_W'(act_syms[$urandom_range(0, act_syms.size() - 1)]);
          b.emit   = ($urandom_range(0, 4) != 0);
          // Mostly a running stream offset, now and then a jump.
          if ($urandom_range(0, 9) != 0) b.position = stream_pos;
          stream_pos = b.position + 1'b1;
        end
      endcase
      send_item(b, 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall bursts, and a check of every accepted beat
  // against the oldest pending match.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
    out_stall <= (stall_left != 0);
  end

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.overflow) overflow_seen++;
      if (pending_matches.size() == 0) begin
        $display({"%0t: match beat with none expected, actual match_pat %h ",
                  "end_position %h last %b overflow %b"},
                 $time, out_data.match_pat, out_data.end_position, out_data.last,
                 out_data.overflow);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        check_field("match_pat", 64'(want.match_pat), 64'(out_data.match_pat));
        check_field("end_position", 64'(want.end_position), 64'(out_data.end_position));
        check_field("last", 64'(want.last), 64'(out_data.last));
        check_field("overflow", 64'(want.overflow), 64'(out_data.overflow));
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout, %0d match beats still expected", $time, pending_matches.size());
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t rows [$];

    // Output entries: a two-entry list (1023 -> 0), a head of a longer list
    // (5 -> 1023 -> 0) and an entry that points at itself.
    rows.push_back(quiet_row(mk_beat(CMD_RESTART, 0, 0, 0, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_ENTRY, 0, 0, 0, LINK_NONE_TOP, 0, 16'hFFFF,
                                     '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_ENTRY, 1023, 0, 0, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_ENTRY, 5, 0, 0, 1023, 0, 16'h1234, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_ENTRY, 9, 0, 0, 9, 0, 16'hBEEF, '0, 1'b0)));
    // Node links: root with nothing, a node with one match, a node with its
    // own list and a suffix, a suffix-only node, and three looping cases.
    rows.push_back(quiet_row(mk_beat(CMD_WR_NODE, 0, 0, 0, LINK_NONE_TOP, LINK_NONE, 0,
                                     '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_NODE, 1023, 0, 0, 0, LINK_NONE, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_NODE, 7, 0, 0, 5, 1023, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_NODE, 2, 0, 0, LINK_NONE, 7, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_NODE, 9, 0, 0, 9, LINK_NONE_TOP, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_NODE, 3, 0, 0, LINK_NONE, 3, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_NODE, 4, 0, 0, 5, 4, 0, '0, 1'b0)));
    // Path 0 -FF-> 1023 -00-> 0 -00-> 7 -AA-> 2 -55-> 9 -01-> 3 -02-> 4.
    rows.push_back(quiet_row(mk_beat(CMD_WR_TRANS, 0, 8'hFF, 1023, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_TRANS, 1023, 8'h00, 0, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_TRANS, 0, 8'h00, 7, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_TRANS, 7, 8'hAA, 2, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_TRANS, 2, 8'h55, 9, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_TRANS, 9, 8'h01, 3, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_WR_TRANS, 3, 8'h02, 4, 0, 0, 0, '0, 1'b0)));
    // Single match at the top stream offset.
    rows.push_back(single_row(mk_beat(CMD_SCAN, 0, 8'hFF, 0, 0, 0, 0, {POS_W{1'b1}}, 1'b1),
                              out_beat_t'{match_pat: 16'hFFFF, end_position: {POS_W{1'b1}},
                                          last: 1'b1, overflow: 1'b0}));
    // Back at the root: no output and no suffix, so nothing comes out.
    rows.push_back(quiet_row(mk_beat(CMD_SCAN, 0, 8'h00, 0, 0, 0, 0, '0, 1'b1)));
    // Own list followed by the suffix node's list.
    rows.push_back(checked_row(mk_beat(CMD_SCAN, 0, 8'h00, 0, 0, 0, 0, 48'd1, 1'b1)));
    // Suffix link only.
    rows.push_back(checked_row(mk_beat(CMD_SCAN, 0, 8'hAA, 0, 0, 0, 0, 48'd2, 1'b1)));
    // Looping output list runs into the per-byte result limit.
    rows.push_back(checked_row(mk_beat(CMD_SCAN, 0, 8'h55, 0, 0, 0, 0, 48'd3, 1'b1)));
    // Self-looping suffix chain with no outputs: a capped walk, no results.
    rows.push_back(quiet_row(mk_beat(CMD_SCAN, 0, 8'h01, 0, 0, 0, 0, 48'd4, 1'b1)));
    // Self-looping suffix chain with outputs: limit reached again.
    rows.push_back(checked_row(mk_beat(CMD_SCAN, 0, 8'h02, 0, 0, 0, 0, 48'd5, 1'b1)));
    // Unused command, restart and a warm-up scan all stay silent.
    rows.push_back(quiet_row(mk_beat(CMD_SPARE_HI, 1023, 8'hFF, 1023, LINK_NONE_TOP,
                                     LINK_NONE_TOP, 16'hFFFF, {POS_W{1'b1}}, 1'b1)));
    rows.push_back(quiet_row(mk_beat(CMD_RESTART, 0, 0, 0, 0, 0, 0, '0, 1'b0)));
    rows.push_back(quiet_row(mk_beat(CMD_SCAN, 0, 8'hFF, 0, 0, 0, 0, 48'd6, 1'b0)));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_item(rows[i].beat, !rows[i].typed);
      if (rows[i].typed && rows[i].has_hit) pending_matches.push_back(rows[i].hit);
    end

    rand_start = live_beats;
    while (live_beats - rand_start < RAND_ITEMS) run_phase();

    in_valid <= 1'b0;
    calm = 1'b1;
    while (pending_matches.size() != 0) @(posedge clk);
    // Let any stray beat surface after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input beats taken (%0d byte scans), %0d match beats checked",
             live_beats, scan_beats, results_seen);
    $display("%0d match beats flagged overflow", overflow_seen);
    $display("covered table loads, suffix chains, looping lists and chains, restarts and stalls");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/acsm_pkg.sv
hdl/acsm_step.sv
hdl/acsm_walk.sv
hdl/aho_corasick_stream_matcher_core.sv
tb/aho_corasick_stream_matcher_core_test.sv
